### rtl/rss_pkg.sv
// rss_pkg: shared types, codes and helpers for the rep string sequencer.
// Used by rss_flags, rss_step and rep_string_sequencer. No dependencies.
package rss_pkg;

	localparam int IN_TDATA_W  = 144;
	localparam int OUT_TDATA_W = 136;

	// string opcodes with the size bit cleared
	localparam logic [7:0] OPC_MOVS = 8'hA4;
	localparam logic [7:0] OPC_CMPS = 8'hA6;
	localparam logic [7:0] OPC_SCAS = 8'hAE;
	localparam logic [7:0] OPC_LODS = 8'hAC;
	localparam logic [7:0] OPC_STOS = 8'hAA;
	localparam logic [7:0] OPC_SEL_MASK = 8'hFE;

	localparam int FLAG_CF = 0;
	localparam int FLAG_PF = 2;
	localparam int FLAG_AF = 4;
	localparam int FLAG_ZF = 6;
	localparam int FLAG_SF = 7;
	localparam int FLAG_DF = 10;
	localparam int FLAG_OF = 11;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WAIT1 = 2'd1,
		PH_WAIT2 = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_MOVS = 3'd1,
		OP_CMPS = 3'd2,
		OP_SCAS = 3'd3,
		OP_LODS = 3'd4,
		OP_STOS = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_WRITE  = 2'd1,
		KIND_DONE   = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ACT_REJECT = 3'd0,
		ACT_DONE   = 3'd1,
		ACT_ISSUE  = 3'd2,
		ACT_WR_DST = 3'd3,
		ACT_RD_DST = 3'd4
	} act_t;

	typedef struct packed {
		logic        func;
		logic [7:0]  opcode;
		logic        repeat_on_zero;
		logic [15:0] count;
		logic [15:0] src_off;
		logic [15:0] dst_off;
		logic [15:0] src_seg;
		logic [15:0] dst_seg;
		logic [15:0] acc;
		logic [15:0] flags_in;
		logic [15:0] read_data;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] seg;
		logic [15:0] off;
		logic        wide;
		logic [15:0] write_data;
		logic [15:0] count_out;
		logic [15:0] src_off_out;
		logic [15:0] dst_off_out;
		logic [15:0] acc_out;
		logic [15:0] flags_out;
	} out_item_t;

	typedef struct packed {
		phase_t      phase;
		op_t         op;
		logic        word;
		logic        zf_cond;
		logic [15:0] remaining;
		logic [15:0] src_off;
		logic [15:0] dst_off;
		logic [15:0] src_seg;
		logic [15:0] dst_seg;
		logic [15:0] acc;
		logic [15:0] flags;
		logic [15:0] first;
	} state_t;

	function automatic logic [15:0] data_mask(input logic word, input logic [15:0] v);
		return word ? v : {8'h00, v[7:0]};
	endfunction

	function automatic op_t decode_op(input logic [7:0] opcode);
		logic [7:0] sel;
		op_t        op;
		sel = opcode & OPC_SEL_MASK;
		unique case (sel)
			OPC_MOVS: op = OP_MOVS;
			OPC_CMPS: op = OP_CMPS;
			OPC_SCAS: op = OP_SCAS;
			OPC_LODS: op = OP_LODS;
			OPC_STOS: op = OP_STOS;
			default:  op = OP_NONE;
		endcase
		return op;
	endfunction

endpackage

### rtl/rss_flags.sv
// rss_flags: CMP flag generation at byte or word width (a - b).
// Depends on rss_pkg.
module rss_flags (
	input  logic [15:0] a,
	input  logic [15:0] b,
	input  logic        word,
	input  logic [15:0] flags_in,
	output logic [15:0] flags_out
);

	logic [15:0] am;
	logic [15:0] bm;
	logic [16:0] diff;
	logic [15:0] r;
	logic [15:0] ovf;

	assign am   = rss_pkg::data_mask(word, a);
	assign bm   = rss_pkg::data_mask(word, b);
	assign diff = {1'b0, am} - {1'b0, bm};
	assign r    = rss_pkg::data_mask(word, diff[15:0]);
	assign ovf  = (am ^ bm) & (am ^ r);

	always_comb begin
		flags_out                   = flags_in;
		flags_out[rss_pkg::FLAG_CF] = diff[16];
		flags_out[rss_pkg::FLAG_PF] = ~^r[7:0];
		flags_out[rss_pkg::FLAG_AF] = (am[4] ^ bm[4] ^ r[4]);
		flags_out[rss_pkg::FLAG_ZF] = (r == 16'h0000);
		flags_out[rss_pkg::FLAG_SF] = word ? r[15] : r[7];
		flags_out[rss_pkg::FLAG_OF] = word ? ovf[15] : ovf[7];
	end

endmodule

### rtl/rss_step.sv
// rss_step: one step of the string loop; next state and result for one item.
// Depends on rss_pkg and rss_flags.
module rss_step (
	input  rss_pkg::state_t    st,
	input  rss_pkg::in_item_t  item,
	output rss_pkg::state_t    st_nxt,
	output rss_pkg::out_item_t res
);

	logic [15:0]    data;
	logic [15:0]    delta;
	logic [15:0]    src_step;
	logic [15:0]    dst_step;
	logic [15:0]    rem_dec;
	logic [15:0]    cmp_a;
	logic [15:0]    cmp_flags;
	logic           go_plain;
	logic           go_cmp;
	rss_pkg::op_t   new_op;
	rss_pkg::act_t  act;

	assign data     = rss_pkg::data_mask(st.word, item.read_data);
	assign delta    = st.word ? 16'd2 : 16'd1;
	assign src_step = st.flags[rss_pkg::FLAG_DF] ? st.src_off - delta : st.src_off + delta;
	assign dst_step = st.flags[rss_pkg::FLAG_DF] ? st.dst_off - delta : st.dst_off + delta;
	assign rem_dec  = st.remaining - 16'd1;
	assign cmp_a    = (st.phase == rss_pkg::PH_WAIT2) ? st.first : st.acc;
	assign go_plain = (rem_dec != 16'd0);
	assign go_cmp   = go_plain && (cmp_flags[rss_pkg::FLAG_ZF] == st.zf_cond);
	assign new_op   = rss_pkg::decode_op(item.opcode);

	rss_flags u_flags (
		.a         (cmp_a),
		.b         (data),
		.word      (st.word),
		.flags_in  (st.flags),
		.flags_out (cmp_flags)
	);

	// next state
	always_comb begin
		st_nxt = st;
		act    = rss_pkg::ACT_REJECT;
		if (!item.func) begin
			if (st.phase == rss_pkg::PH_IDLE) begin
				st_nxt.word      = item.opcode[0];
				st_nxt.zf_cond   = item.repeat_on_zero;
				st_nxt.remaining = item.count;
				st_nxt.src_off   = item.src_off;
				st_nxt.dst_off   = item.dst_off;
				st_nxt.src_seg   = item.src_seg;
				st_nxt.dst_seg   = item.dst_seg;
				st_nxt.acc       = item.acc;
				st_nxt.flags     = item.flags_in;
				st_nxt.first     = 16'h0000;
				st_nxt.op        = new_op;
				if (new_op == rss_pkg::OP_NONE || item.count == 16'd0) begin
					st_nxt.phase = rss_pkg::PH_IDLE;
					act          = rss_pkg::ACT_DONE;
				end else begin
					st_nxt.phase = rss_pkg::PH_WAIT1;
					act          = rss_pkg::ACT_ISSUE;
				end
			end
		end else begin
			st_nxt.phase = rss_pkg::PH_IDLE;
			if (st.phase == rss_pkg::PH_WAIT1) begin
				unique case (st.op)
					rss_pkg::OP_MOVS: begin
						st_nxt.first = data;
						st_nxt.phase = rss_pkg::PH_WAIT2;
						act          = rss_pkg::ACT_WR_DST;
					end
					rss_pkg::OP_CMPS: begin
						st_nxt.first = data;
						st_nxt.phase = rss_pkg::PH_WAIT2;
						act          = rss_pkg::ACT_RD_DST;
					end
					rss_pkg::OP_SCAS: begin
						st_nxt.flags     = cmp_flags;
						st_nxt.dst_off   = dst_step;
						st_nxt.remaining = rem_dec;
						st_nxt.phase     = go_cmp ? rss_pkg::PH_WAIT1 : rss_pkg::PH_IDLE;
						act              = go_cmp ? rss_pkg::ACT_ISSUE : rss_pkg::ACT_DONE;
					end
					rss_pkg::OP_LODS: begin
						st_nxt.acc       = st.word ? data : {st.acc[15:8], data[7:0]};
						st_nxt.src_off   = src_step;
						st_nxt.remaining = rem_dec;
						st_nxt.phase     = go_plain ? rss_pkg::PH_WAIT1 : rss_pkg::PH_IDLE;
						act              = go_plain ? rss_pkg::ACT_ISSUE : rss_pkg::ACT_DONE;
					end
					rss_pkg::OP_STOS: begin
						st_nxt.dst_off   = dst_step;
						st_nxt.remaining = rem_dec;
						st_nxt.phase     = go_plain ? rss_pkg::PH_WAIT1 : rss_pkg::PH_IDLE;
						act              = go_plain ? rss_pkg::ACT_ISSUE : rss_pkg::ACT_DONE;
					end
					default: begin
						act = rss_pkg::ACT_REJECT;
					end
				endcase
			end else if (st.phase == rss_pkg::PH_WAIT2 &&
					(st.op == rss_pkg::OP_MOVS || st.op == rss_pkg::OP_CMPS)) begin
				st_nxt.src_off   = src_step;
				st_nxt.dst_off   = dst_step;
				st_nxt.remaining = rem_dec;
				if (st.op == rss_pkg::OP_CMPS) begin
					st_nxt.flags = cmp_flags;
					st_nxt.phase = go_cmp ? rss_pkg::PH_WAIT1 : rss_pkg::PH_IDLE;
					act          = go_cmp ? rss_pkg::ACT_ISSUE : rss_pkg::ACT_DONE;
				end else begin
					st_nxt.phase = go_plain ? rss_pkg::PH_WAIT1 : rss_pkg::PH_IDLE;
					act          = go_plain ? rss_pkg::ACT_ISSUE : rss_pkg::ACT_DONE;
				end
			end
		end
	end

	// result
	always_comb begin
		res      = '0;
		res.kind = rss_pkg::KIND_REJECT;
		unique case (act)
			rss_pkg::ACT_DONE: begin
				res.kind        = rss_pkg::KIND_DONE;
				res.count_out   = st_nxt.remaining;
				res.src_off_out = st_nxt.src_off;
				res.dst_off_out = st_nxt.dst_off;
				res.acc_out     = st_nxt.acc;
				res.flags_out   = st_nxt.flags;
			end
			rss_pkg::ACT_ISSUE: begin
				res.wide = st_nxt.word;
				unique case (st_nxt.op)
					rss_pkg::OP_SCAS: begin
						res.kind = rss_pkg::KIND_READ;
						res.seg  = st_nxt.dst_seg;
						res.off  = st_nxt.dst_off;
					end
					rss_pkg::OP_STOS: begin
						res.kind       = rss_pkg::KIND_WRITE;
						res.seg        = st_nxt.dst_seg;
						res.off        = st_nxt.dst_off;
						res.write_data = rss_pkg::data_mask(st_nxt.word, st_nxt.acc);
					end
					default: begin
						res.kind = rss_pkg::KIND_READ;
						res.seg  = st_nxt.src_seg;
						res.off  = st_nxt.src_off;
					end
				endcase
			end
			rss_pkg::ACT_WR_DST: begin
				res.kind       = rss_pkg::KIND_WRITE;
				res.seg        = st_nxt.dst_seg;
				res.off        = st_nxt.dst_off;
				res.wide       = st_nxt.word;
				res.write_data = data;
			end
			rss_pkg::ACT_RD_DST: begin
				res.kind = rss_pkg::KIND_READ;
				res.seg  = st_nxt.dst_seg;
				res.off  = st_nxt.dst_off;
				res.wide = st_nxt.word;
			end
			default: begin
				res.kind = rss_pkg::KIND_REJECT;
			end
		endcase
	end

endmodule

### rtl/rep_string_sequencer.sv
// rep_string_sequencer: sequencer for repeated x86 string instructions.
// Depends on rss_pkg and rss_step.
//
// Usage:
//   s_axis carries start items (tuser = 0) and memory response items
//   (tuser = 1). A start loads MOVS/CMPS/SCAS/LODS/STOS with its registers;
//   every item gives exactly one m_axis item: a read or write request,
//   a done item with the final CX, SI, DI, AX and flags, or a reject.
//   The requester answers each request with one response item; write
//   requests are answered too, with read_data ignored.
//   Throughput: one item per cycle unless m_axis stalls; the step for one item
//   is a single pass through rss_step between the input and result registers.
//   Reset clears the loop state to idle and empties both registers.
//   When m_axis stalls, the result register holds, the input register fills
//   and s_axis_tready then drops until the result is taken.
module rep_string_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// opcode, repeat_on_zero, count, src_off, dst_off, src_seg, dst_seg, acc,
	// flags_in, read_data, zero pad
	input  logic [rss_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// func
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// seg, off, wide, write_data, count_out, src_off_out, dst_off_out,
	// acc_out, flags_out, zero pad
	output logic [rss_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// kind
	output logic [1:0]                          m_axis_tuser
);

	logic               valid_s1;
	rss_pkg::in_item_t  item_s1;
	logic               valid_s2;
	rss_pkg::out_item_t res_s2;
	rss_pkg::state_t    st_q;
	rss_pkg::state_t    st_nxt;
	rss_pkg::out_item_t res;
	rss_pkg::in_item_t  item_in;
	logic               advance;
	logic               take;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take          = s_axis_tvalid && s_axis_tready;

	assign item_in.func           = s_axis_tuser;
	assign item_in.opcode         = s_axis_tdata[7:0];
	assign item_in.repeat_on_zero = s_axis_tdata[8];
	assign item_in.count          = s_axis_tdata[24:9];
	assign item_in.src_off        = s_axis_tdata[40:25];
	assign item_in.dst_off        = s_axis_tdata[56:41];
	assign item_in.src_seg        = s_axis_tdata[72:57];
	assign item_in.dst_seg        = s_axis_tdata[88:73];
	assign item_in.acc            = s_axis_tdata[104:89];
	assign item_in.flags_in       = s_axis_tdata[120:105];
	assign item_in.read_data      = s_axis_tdata[136:121];

	rss_step u_step (
		.st     (st_q),
		.item   (item_s1),
		.st_nxt (st_nxt),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				st_q     <= st_nxt;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tdata  = {7'd0, res_s2.flags_out, res_s2.acc_out, res_s2.dst_off_out,
		res_s2.src_off_out, res_s2.count_out, res_s2.write_data, res_s2.wide,
		res_s2.off, res_s2.seg};

	a_busy_start_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !item_s1.func && st_q.phase != rss_pkg::PH_IDLE
		|=> m_axis_tvalid && m_axis_tuser == rss_pkg::KIND_REJECT)
		else $error("start while busy not rejected");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.kind == rss_pkg::KIND_DONE |=> st_q.phase == rss_pkg::PH_IDLE)
		else $error("done result without return to idle");

	a_wait2_op: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == rss_pkg::PH_WAIT2
		|-> st_q.op == rss_pkg::OP_MOVS || st_q.op == rss_pkg::OP_CMPS)
		else $error("second access phase for a single access operation");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a stalled item");

endmodule

### tb/rss_result_checker.sv
`timescale 1ns / 1ps
// rss_result_checker: watches both stream channels of rep_string_sequencer, predicts
// each result from its own copy of the loop state and compares it field by field.
// Depends on rss_pkg.
module rss_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [rss_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                            s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [rss_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic [1:0]                      m_axis_tuser,
	output int                              mismatches,
	output int                              awaited
);

	rss_pkg::phase_t seq_phase;
	rss_pkg::op_t    seq_op;
	logic            seq_word;
	logic            seq_zf_cond;
	logic [15:0]     seq_cx;
	logic [15:0]     seq_si;
	logic [15:0]     seq_di;
	logic [15:0]     seq_ds;
	logic [15:0]     seq_es;
	logic [15:0]     seq_ax;
	logic [15:0]     seq_flags;
	logic [15:0]     seq_first;

	rss_pkg::out_item_t pending_results[$];

	function automatic logic [15:0] step_offset(input logic [15:0] v);
		logic [15:0] d;
		d = seq_word ? 16'd2 : 16'd1;
		return seq_flags[rss_pkg::FLAG_DF] ? v - d : v + d;
	endfunction

	// CMP flags of a minus b at the access width
	function automatic void cmp_flags(input logic [15:0] a_in, input logic [15:0] b_in);
		logic [15:0] m, top, a, b, r, f;
		m = seq_word ? 16'hFFFF : 16'h00FF;
		top = seq_word ? 16'h8000 : 16'h0080;
		a = a_in & m;
		b = b_in & m;
		r = (a - b) & m;
		f = seq_flags;
		f[rss_pkg::FLAG_CF] = a < b;
		f[rss_pkg::FLAG_PF] = ~^r[7:0];
		f[rss_pkg::FLAG_AF] = a[4] ^ b[4] ^ r[4];
		f[rss_pkg::FLAG_ZF] = r == 16'h0000;
		f[rss_pkg::FLAG_SF] = |(r & top);
		f[rss_pkg::FLAG_OF] = |((a ^ b) & (a ^ r) & top);
		seq_flags = f;
	endfunction

	function automatic rss_pkg::out_item_t access(input rss_pkg::kind_t k,
		input logic [15:0] seg, input logic [15:0] off, input logic [15:0] wdata);
		rss_pkg::out_item_t o;
		o = '0;
		o.kind = k;
		o.seg = seg;
		o.off = off;
		o.wide = seq_word;
		o.write_data = wdata;
		return o;
	endfunction

	function automatic rss_pkg::out_item_t done_result();
		rss_pkg::out_item_t o;
		o = '0;
		o.kind = rss_pkg::KIND_DONE;
		o.count_out = seq_cx;
		o.src_off_out = seq_si;
		o.dst_off_out = seq_di;
		o.acc_out = seq_ax;
		o.flags_out = seq_flags;
		seq_phase = rss_pkg::PH_IDLE;
		return o;
	endfunction

	function automatic rss_pkg::out_item_t first_access();
		seq_phase = rss_pkg::PH_WAIT1;
		case (seq_op)
			rss_pkg::OP_SCAS: return access(rss_pkg::KIND_READ, seq_es, seq_di, 16'h0000);
			rss_pkg::OP_STOS: return access(rss_pkg::KIND_WRITE, seq_es, seq_di,
				seq_word ? seq_ax : {8'h00, seq_ax[7:0]});
			default: return access(rss_pkg::KIND_READ, seq_ds, seq_si, 16'h0000);
		endcase
	endfunction

	function automatic rss_pkg::out_item_t end_iteration(input logic use_cond);
		seq_cx = seq_cx - 16'd1;
		if (seq_cx != 16'h0000 &&
			(!use_cond || seq_flags[rss_pkg::FLAG_ZF] == seq_zf_cond))
			return first_access();
		return done_result();
	endfunction

	function automatic rss_pkg::out_item_t predict_string_step(input rss_pkg::in_item_t it);
		rss_pkg::out_item_t rej;
		logic [15:0]        rd;
		rej = '0;
		rej.kind = rss_pkg::KIND_REJECT;
		if (!it.func) begin
			if (seq_phase != rss_pkg::PH_IDLE)
				return rej;
			seq_word = it.opcode[0];
			seq_zf_cond = it.repeat_on_zero;
			seq_cx = it.count;
			seq_si = it.src_off;
			seq_di = it.dst_off;
			seq_ds = it.src_seg;
			seq_es = it.dst_seg;
			seq_ax = it.acc;
			seq_flags = it.flags_in;
			seq_first = 16'h0000;
			case (it.opcode & rss_pkg::OPC_SEL_MASK)
				rss_pkg::OPC_MOVS: seq_op = rss_pkg::OP_MOVS;
				rss_pkg::OPC_CMPS: seq_op = rss_pkg::OP_CMPS;
				rss_pkg::OPC_SCAS: seq_op = rss_pkg::OP_SCAS;
				rss_pkg::OPC_LODS: seq_op = rss_pkg::OP_LODS;
				rss_pkg::OPC_STOS: seq_op = rss_pkg::OP_STOS;
				default:           seq_op = rss_pkg::OP_NONE;
			endcase
			if (seq_op == rss_pkg::OP_NONE || seq_cx == 16'h0000)
				return done_result();
			return first_access();
		end
		rd = seq_word ? it.read_data : {8'h00, it.read_data[7:0]};
		if (seq_phase == rss_pkg::PH_WAIT1) begin
			case (seq_op)
				rss_pkg::OP_MOVS: begin
					seq_first = rd;
					seq_phase = rss_pkg::PH_WAIT2;
					return access(rss_pkg::KIND_WRITE, seq_es, seq_di, rd);
				end
				rss_pkg::OP_CMPS: begin
					seq_first = rd;
					seq_phase = rss_pkg::PH_WAIT2;
					return access(rss_pkg::KIND_READ, seq_es, seq_di, 16'h0000);
				end
				rss_pkg::OP_SCAS: begin
					cmp_flags(seq_ax, rd);
					seq_di = step_offset(seq_di);
					return end_iteration(1'b1);
				end
				rss_pkg::OP_LODS: begin
					seq_ax = seq_word ? rd : {seq_ax[15:8], rd[7:0]};
					seq_si = step_offset(seq_si);
					return end_iteration(1'b0);
				end
				rss_pkg::OP_STOS: begin
					seq_di = step_offset(seq_di);
					return end_iteration(1'b0);
				end
				default: ;
			endcase
		end else if (seq_phase == rss_pkg::PH_WAIT2 &&
			(seq_op == rss_pkg::OP_MOVS || seq_op == rss_pkg::OP_CMPS)) begin
			if (seq_op == rss_pkg::OP_CMPS)
				cmp_flags(seq_first, rd);
			seq_si = step_offset(seq_si);
			seq_di = step_offset(seq_di);
			return end_iteration(seq_op == rss_pkg::OP_CMPS);
		end
		seq_phase = rss_pkg::PH_IDLE;
		return rej;
	endfunction

	task automatic check_field(input string field, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rss_pkg::in_item_t  taken;
		rss_pkg::out_item_t seen;
		rss_pkg::out_item_t want;
		if (!arst_n) begin
			seq_phase = rss_pkg::PH_IDLE;
			seq_op = rss_pkg::OP_NONE;
			seq_word = 1'b0;
			seq_zf_cond = 1'b0;
			seq_cx = '0;
			seq_si = '0;
			seq_di = '0;
			seq_ds = '0;
			seq_es = '0;
			seq_ax = '0;
			seq_flags = '0;
			seq_first = '0;
			pending_results.delete();
			mismatches = 0;
			awaited <= 0;
		end else begin
			// results first, so an item taken at this edge cannot match itself
			if (m_axis_tvalid && m_axis_tready) begin
				seen = '0;
				seen.kind = rss_pkg::kind_t'(m_axis_tuser);
				{seen.flags_out, seen.acc_out, seen.dst_off_out, seen.src_off_out,
					seen.count_out, seen.write_data, seen.wide, seen.off,
					seen.seg} = m_axis_tdata[128:0];
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result of kind %0d with nothing expected",
							$realtime, seen.kind);
				end else begin
					want = pending_results.pop_front();
					check_field("kind", 16'(want.kind), 16'(seen.kind));
					check_field("seg", want.seg, seen.seg);
					check_field("off", want.off, seen.off);
					check_field("wide", 16'(want.wide), 16'(seen.wide));
					check_field("write_data", want.write_data, seen.write_data);
					check_field("count_out", want.count_out, seen.count_out);
					check_field("src_off_out", want.src_off_out, seen.src_off_out);
					check_field("dst_off_out", want.dst_off_out, seen.dst_off_out);
					check_field("acc_out", want.acc_out, seen.acc_out);
					check_field("flags_out", want.flags_out, seen.flags_out);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				taken.func = s_axis_tuser;
				{taken.read_data, taken.flags_in, taken.acc, taken.dst_seg, taken.src_seg,
					taken.dst_off, taken.src_off, taken.count, taken.repeat_on_zero,
					taken.opcode} = s_axis_tdata[136:0];
				pending_results.push_back(predict_string_step(taken));
			end
			awaited <= pending_results.size();
		end
	end

endmodule

### tb/rep_string_sequencer_test.sv
`timescale 1ns / 1ps
// rep_string_sequencer_test: drives start and memory response items into
// rep_string_sequencer, stalls the result side and reports the verdict.
// Depends on rss_pkg, rep_string_sequencer and rss_result_checker.
module rep_string_sequencer_test;

	localparam int ITEM_TOTAL  = 1850;
	localparam int CYCLE_LIMIT = 200000;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [rss_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                            s_axis_tuser = 1'b0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [rss_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]                      m_axis_tuser;
	logic                            rx_hold = 1'b0;

	int mismatches;
	int awaited;
	int items_sent = 0;
	int tx_idle_pct = 38;
	int rx_idle_pct = 78;
	int cycle_count = 0;

	rep_string_sequencer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	rss_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.awaited       (awaited)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk)
		m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

	// long result stall while items keep coming, so the block backs up
	initial begin
		wait (items_sent >= 1300);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	function automatic logic [15:0] pick16();
		logic [15:0] v;
		v = 16'($urandom);
		case ($urandom_range(15))
			0: v = 16'h0000;
			1: v = 16'hFFFF;
			default: ;
		endcase
		return v;
	endfunction

	function automatic rss_pkg::in_item_t random_item(input logic fn);
		rss_pkg::in_item_t it;
		it.func = fn;
		it.opcode = 8'($urandom_range(255));
		it.repeat_on_zero = 1'($urandom_range(1));
		it.count = pick16();
		it.src_off = pick16();
		it.dst_off = pick16();
		it.src_seg = pick16();
		it.dst_seg = pick16();
		it.acc = pick16();
		it.flags_in = pick16();
		it.read_data = pick16();
		return it;
	endfunction

	// data that makes the compare against other set ZF as asked
	function automatic logic [15:0] zf_data(input logic [15:0] other, input logic [15:0] d,
		input logic [15:0] m, input logic eq);
		if (eq)
			return (d & ~m) | (other & m);
		if (((d ^ other) & m) == 16'h0000)
			return d ^ (16'h0001 << $urandom_range(m[8] ? 15 : 7));
		return d;
	endfunction

	task automatic send_item(input rss_pkg::in_item_t it);
		if (items_sent < 620) begin
			tx_idle_pct = 38;
			rx_idle_pct = 78;
		end else if (items_sent < 1240) begin
			tx_idle_pct = 78;
			rx_idle_pct = 38;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.func;
		s_axis_tdata <= {7'd0, it.read_data, it.flags_in, it.acc, it.dst_seg, it.src_seg,
			it.dst_off, it.src_off, it.count, it.repeat_on_zero, it.opcode};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// one instruction: start, then the responses it asks for; compares end
	// on iteration stop_at, and only cut_at iterations are answered
	task automatic run_string_op(input rss_pkg::in_item_t start, input int stop_at,
		input int cut_at);
		rss_pkg::in_item_t rsp;
		logic [7:0]        sel;
		logic [15:0]       m;
		logic [15:0]       first;
		logic              want_zf;
		int                iters;
		int                i;
		start.func = 1'b0;
		send_item(start);
		sel = start.opcode & rss_pkg::OPC_SEL_MASK;
		m = start.opcode[0] ? 16'hFFFF : 16'h00FF;
		iters = start.count;
		if (sel != rss_pkg::OPC_MOVS && sel != rss_pkg::OPC_CMPS &&
			sel != rss_pkg::OPC_SCAS && sel != rss_pkg::OPC_LODS &&
			sel != rss_pkg::OPC_STOS)
			iters = 0;
		if ((sel == rss_pkg::OPC_CMPS || sel == rss_pkg::OPC_SCAS) && stop_at < iters)
			iters = stop_at;
		if (cut_at < iters)
			iters = cut_at;
		for (i = 1; i <= iters; i++) begin
			want_zf = (i == stop_at) ? !start.repeat_on_zero : start.repeat_on_zero;
			if ($urandom_range(29) == 0) begin
				rsp = random_item(1'b0);
				rsp.count = 16'($urandom_range(3));
				send_item(rsp);
			end
			rsp = random_item(1'b1);
			if (sel == rss_pkg::OPC_SCAS)
				rsp.read_data = zf_data(start.acc, rsp.read_data, m, want_zf);
			send_item(rsp);
			if (sel == rss_pkg::OPC_MOVS || sel == rss_pkg::OPC_CMPS) begin
				first = rsp.read_data;
				rsp = random_item(1'b1);
				if (sel == rss_pkg::OPC_CMPS)
					rsp.read_data = zf_data(first, rsp.read_data, m, want_zf);
				send_item(rsp);
			end
		end
	endtask

	initial begin : stimulus
		rss_pkg::in_item_t it;
		logic [7:0]        sel;
		logic              is_cmp;
		int                r;
		int                cut;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// response with nothing running
		it = random_item(1'b1);
		it.read_data = 16'hFFFF;
		send_item(it);
		// unknown opcode finishes at once
		it = random_item(1'b0);
		it.opcode = 8'h00;
		it.count = 16'd5;
		run_string_op(it, 99, 99);
		// zero count, every field at its top value
		it = '1;
		it.opcode = rss_pkg::OPC_MOVS | 8'h01;
		it.count = 16'h0000;
		run_string_op(it, 99, 99);
		// byte LODS keeps AH
		it = random_item(1'b0);
		it.opcode = rss_pkg::OPC_LODS;
		it.count = 16'd1;
		it.acc = 16'hABCD;
		run_string_op(it, 99, 99);
		// word STOS downwards across zero, second start while busy
		it = random_item(1'b0);
		it.opcode = rss_pkg::OPC_STOS | 8'h01;
		it.count = 16'd1;
		it.dst_off = 16'h0000;
		it.flags_in[rss_pkg::FLAG_DF] = 1'b1;
		send_item(it);
		it.opcode = rss_pkg::OPC_LODS;
		send_item(it);
		send_item(random_item(1'b1));
		// word MOVS downwards from the bottom of the segment
		it = random_item(1'b0);
		it.opcode = rss_pkg::OPC_MOVS | 8'h01;
		it.count = 16'd2;
		it.src_off = 16'h0000;
		it.dst_off = 16'h0001;
		it.flags_in[rss_pkg::FLAG_DF] = 1'b1;
		run_string_op(it, 99, 99);
		// byte REPE CMPS, first pair unequal
		it = random_item(1'b0);
		it.opcode = rss_pkg::OPC_CMPS;
		it.repeat_on_zero = 1'b1;
		it.count = 16'd3;
		it.flags_in = 16'h0000;
		run_string_op(it, 1, 99);
		// word REPNE SCAS from full count, stops on a match
		it = random_item(1'b0);
		it.opcode = rss_pkg::OPC_SCAS | 8'h01;
		it.repeat_on_zero = 1'b0;
		it.count = 16'hFFFF;
		it.flags_in = 16'hFFFF;
		run_string_op(it, 2, 99);

		while (items_sent < ITEM_TOTAL) begin
			it = random_item(1'b0);
			r = $urandom_range(99);
			if (r < 8) begin
				// stray start never served, or response with nothing asked
				it.func = 1'($urandom_range(1));
				it.count = 16'($urandom_range(3));
				send_item(it);
			end else begin
				if (r < 16) begin
					it.opcode = 8'($urandom_range(255));
				end else begin
					case ($urandom_range(4))
						0: sel = rss_pkg::OPC_MOVS;
						1: sel = rss_pkg::OPC_CMPS;
						2: sel = rss_pkg::OPC_SCAS;
						3: sel = rss_pkg::OPC_LODS;
						default: sel = rss_pkg::OPC_STOS;
					endcase
					it.opcode = sel | 8'($urandom_range(1));
				end
				sel = it.opcode & rss_pkg::OPC_SEL_MASK;
				is_cmp = sel == rss_pkg::OPC_CMPS || sel == rss_pkg::OPC_SCAS;
				case ($urandom_range(9))
					0: it.count = 16'h0000;
					1: it.count = is_cmp ? pick16() : 16'($urandom_range(5, 12));
					default: it.count = 16'($urandom_range(1, 4));
				endcase
				cut = 99;
				if ($urandom_range(19) == 0 && it.count <= 16'd12)
					cut = $urandom_range(0, it.count);
				run_string_op(it, $urandom_range(1, 8), cut);
			end
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
rtl/rss_pkg.sv
rtl/rss_flags.sv
rtl/rss_step.sv
rtl/rep_string_sequencer.sv
tb/rss_result_checker.sv
tb/rep_string_sequencer_test.sv
